>>> hw/rtl/pic_pkg.sv
// Shared types, port offsets and helpers for the cascaded interrupt controller pair.
`default_nettype none
package pic_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RAISE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_OPER = 2'd0,
        PH_ICW2 = 2'd1,
        PH_ICW3 = 2'd2,
        PH_ICW4 = 2'd3
    } t_init_phase;

    typedef struct packed {
        logic       cmd_rd;
        logic       cmd_wr;
        logic       data_wr;
        logic       raise;
        logic [2:0] line;
    } t_pic_cmd;

    localparam logic [11:0] PORT_MASTER_CMD  = 12'h020;
    localparam logic [11:0] PORT_MASTER_DATA = 12'h021;
    localparam logic [11:0] PORT_SLAVE_CMD   = 12'h0A0;
    localparam logic [11:0] PORT_SLAVE_DATA  = 12'h0A1;
    localparam logic [11:0] PORT_ELC0        = 12'h4D0;
    localparam logic [11:0] PORT_ELC1        = 12'h4D1;

    localparam int unsigned CASCADE_BIT = 2;

    // lowest set bit, 7 when none below it is set
    function automatic logic [2:0] lowest_bit(input logic [7:0] v);
        logic [2:0] b;
        b = 3'd7;
        for (int i = 6; i >= 0; i--) begin
            if (v[i]) begin
                b = 3'(i);
            end
        end
        return b;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pic_core.sv
// One 8259A-style controller: request, mask and in-service registers with ICW/OCW decode.
`default_nettype none
module pic_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire pic_pkg::t_pic_cmd i_cmd,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_casc_en,
    input  wire logic              i_casc_level,
    output logic [7:0]             o_cmd_rdata,
    output logic [7:0]             o_mask,
    output logic                   o_next_pending
);

    logic [7:0]           r_req, n_req;
    logic [7:0]           r_mask, n_mask;
    logic [7:0]           r_isr, n_isr;
    pic_pkg::t_init_phase r_phase, n_phase;
    logic                 r_need4, n_need4;
    logic                 r_single, n_single;
    logic                 r_show, n_show;
    logic                 r_poll, n_poll;

    logic [7:0] pend;
    logic [2:0] poll_bit;
    logic [2:0] isr_low;

    assign pend     = r_req & ~r_mask;
    assign poll_bit = pic_pkg::lowest_bit(pend);
    assign isr_low  = pic_pkg::lowest_bit(r_isr);

    always_comb begin
        if (r_poll) begin
            o_cmd_rdata = (pend == 8'd0) ? 8'd0 : {5'b10000, poll_bit};
        end else begin
            o_cmd_rdata = r_show ? r_isr : r_req;
        end
    end

    always_comb begin
        n_req    = r_req;
        n_mask   = r_mask;
        n_isr    = r_isr;
        n_phase  = r_phase;
        n_need4  = r_need4;
        n_single = r_single;
        n_show   = r_show;
        n_poll   = r_poll;
        if (i_fire) begin
            if (i_cmd.cmd_wr) begin
                if (i_wdata[4]) begin
                    n_need4  = i_wdata[0];
                    n_single = i_wdata[1];
                    n_mask   = 8'd0;
                    n_isr    = 8'd0;
                    n_show   = 1'b0;
                    n_poll   = 1'b0;
                    n_phase  = pic_pkg::PH_ICW2;
                end else if (i_wdata[3]) begin
                    if (i_wdata[2]) begin
                        n_poll = 1'b1;
                    end else if (i_wdata[1]) begin
                        n_show = i_wdata[0];
                    end
                end else if (i_wdata[5]) begin
                    if (i_wdata[6]) begin
                        n_isr[i_wdata[2:0]] = 1'b0;
                    end else if (r_isr != 8'd0) begin
                        n_isr[isr_low] = 1'b0;
                    end
                end
            end
            if (i_cmd.data_wr) begin
                unique case (r_phase)
                    pic_pkg::PH_ICW2: begin
                        n_phase = r_single ? (r_need4 ? pic_pkg::PH_ICW4 : pic_pkg::PH_OPER)
                                           : pic_pkg::PH_ICW3;
                    end
                    pic_pkg::PH_ICW3: begin
                        n_phase = r_need4 ? pic_pkg::PH_ICW4 : pic_pkg::PH_OPER;
                    end
                    pic_pkg::PH_ICW4: begin
                        n_phase = pic_pkg::PH_OPER;
                    end
                    default: begin
                        n_mask = i_wdata;
                    end
                endcase
            end
            if (i_cmd.cmd_rd && r_poll) begin
                n_poll = 1'b0;
                if (pend != 8'd0) begin
                    n_isr[poll_bit] = 1'b1;
                    n_req[poll_bit] = 1'b0;
                end
            end
            if (i_cmd.raise) begin
                n_req[i_cmd.line] = 1'b1;
            end
        end
        if (i_casc_en) begin
            n_req[pic_pkg::CASCADE_BIT] = i_casc_level;
        end
    end

    assign o_mask         = r_mask;
    assign o_next_pending = |(n_req & ~n_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req    <= 8'd0;
            r_mask   <= 8'd0;
            r_isr    <= 8'd0;
            r_phase  <= pic_pkg::PH_OPER;
            r_need4  <= 1'b0;
            r_single <= 1'b0;
            r_show   <= 1'b0;
            r_poll   <= 1'b0;
        end else begin
            r_req    <= n_req;
            r_mask   <= n_mask;
            r_isr    <= n_isr;
            r_phase  <= n_phase;
            r_need4  <= n_need4;
            r_single <= n_single;
            r_show   <= n_show;
            r_poll   <= n_poll;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/cascaded_8259_interrupt_controller_pair.sv
// Top level: master/slave 8259A-style pair with edge/level control bytes behind byte ports.
//
// Input channel: i_valid / o_stall carries one beat per bus access or request
// raise (i_operation: read, write, raise). Output channel: o_valid / i_stall
// returns one beat per input beat, in order, with the read byte, the master
// interrupt level after the access, and an error flag for unsupported offsets.
// A beat is captured in the input register, decoded and applied to both
// controllers once the output register can take its result, and that result
// lands in the output register, which drives o_valid. One beat per cycle is
// sustained while i_stall is low; the state update of each beat is registered
// at the same edge as its result, so the next beat always sees it.
// While i_stall holds a result, the output register keeps it and the input
// register holds one more beat; o_stall rises only when both are full.
// Synchronous reset clears all masks, requests, in-service bits, modes and
// control bytes and empties both registers.
`default_nettype none
module cascaded_8259_interrupt_controller_pair (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [11:0] i_port_offset,
    input  wire logic [7:0]  i_write_data,
    input  wire logic [3:0]  i_request_line,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_read_data,
    output logic             o_irq_level,
    output logic             o_access_error
);

    logic        r_in_valid;
    pic_pkg::t_op r_op;
    logic [11:0] r_off;
    logic [7:0]  r_wd;
    logic [3:0]  r_line;

    logic        r_out_valid;
    logic [7:0]  r_rd;
    logic        r_irq;
    logic        r_err;

    logic [7:0]  r_elc0, n_elc0;
    logic [7:0]  r_elc1, n_elc1;

    logic        advance;
    logic        fire;
    logic        is_rd, is_wr;
    pic_pkg::t_pic_cmd m_cmd, s_cmd;
    logic [7:0]  m_cmd_rdata, s_cmd_rdata, m_mask, s_mask;
    logic        m_pend, s_pend;
    logic [7:0]  rd;
    logic        err;

    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    assign is_rd = (r_op == pic_pkg::OP_READ);
    assign is_wr = (r_op == pic_pkg::OP_WRITE);

    always_comb begin
        m_cmd.cmd_rd  = is_rd && (r_off == pic_pkg::PORT_MASTER_CMD);
        m_cmd.cmd_wr  = is_wr && (r_off == pic_pkg::PORT_MASTER_CMD);
        m_cmd.data_wr = is_wr && (r_off == pic_pkg::PORT_MASTER_DATA);
        m_cmd.raise   = (r_op == pic_pkg::OP_RAISE) && !r_line[3];
        m_cmd.line    = r_line[2:0];
        s_cmd.cmd_rd  = is_rd && (r_off == pic_pkg::PORT_SLAVE_CMD);
        s_cmd.cmd_wr  = is_wr && (r_off == pic_pkg::PORT_SLAVE_CMD);
        s_cmd.data_wr = is_wr && (r_off == pic_pkg::PORT_SLAVE_DATA);
        s_cmd.raise   = (r_op == pic_pkg::OP_RAISE) && r_line[3];
        s_cmd.line    = r_line[2:0];
    end

    pic_core u_master (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cmd          (m_cmd),
        .i_wdata        (r_wd),
        .i_casc_en      (1'b1),
        .i_casc_level   (s_pend),
        .o_cmd_rdata    (m_cmd_rdata),
        .o_mask         (m_mask),
        .o_next_pending (m_pend)
    );

    pic_core u_slave (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_cmd          (s_cmd),
        .i_wdata        (r_wd),
        .i_casc_en      (1'b0),
        .i_casc_level   (1'b0),
        .o_cmd_rdata    (s_cmd_rdata),
        .o_mask         (s_mask),
        .o_next_pending (s_pend)
    );

    always_comb begin
        rd  = 8'd0;
        err = 1'b0;
        if (is_rd || is_wr) begin
            unique case (r_off)
                pic_pkg::PORT_MASTER_CMD:  rd = is_rd ? m_cmd_rdata : 8'd0;
                pic_pkg::PORT_MASTER_DATA: rd = is_rd ? m_mask : 8'd0;
                pic_pkg::PORT_SLAVE_CMD:   rd = is_rd ? s_cmd_rdata : 8'd0;
                pic_pkg::PORT_SLAVE_DATA:  rd = is_rd ? s_mask : 8'd0;
                pic_pkg::PORT_ELC0:        rd = is_rd ? r_elc0 : 8'd0;
                pic_pkg::PORT_ELC1:        rd = is_rd ? r_elc1 : 8'd0;
                default:                   err = 1'b1;
            endcase
        end
    end

    always_comb begin
        n_elc0 = r_elc0;
        n_elc1 = r_elc1;
        if (fire && is_wr && (r_off == pic_pkg::PORT_ELC0)) begin
            n_elc0 = r_wd;
        end
        if (fire && is_wr && (r_off == pic_pkg::PORT_ELC1)) begin
            n_elc1 = r_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_elc0      <= 8'd0;
            r_elc1      <= 8'd0;
        end else begin
            r_elc0 <= n_elc0;
            r_elc1 <= n_elc1;
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op   <= pic_pkg::t_op'(i_operation);
            r_off  <= i_port_offset;
            r_wd   <= i_write_data;
            r_line <= i_request_line;
        end
        if (fire) begin
            r_rd  <= rd;
            r_irq <= m_pend;
            r_err <= err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_rd;
    assign o_irq_level    = r_irq;
    assign o_access_error = r_err;

endmodule
`default_nettype wire

>>> hw/rtl/pic_chk.sv
// Port-level checker for the cascaded interrupt controller pair, with its bind.
`default_nettype none
module pic_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_read_data,
    input wire logic        o_access_error
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data))
        else $error("stalled result changed");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_access_error |-> o_read_data == 8'd0)
        else $error("error beat carries data");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind cascaded_8259_interrupt_controller_pair pic_chk u_pic_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_read_data    (o_read_data),
    .o_access_error (o_access_error)
);
`default_nettype wire

>>> tb/sv/cascaded_8259_interrupt_controller_pair_tb.sv
// Self-checking testbench for the cascaded 8259-style controller pair: predicted bus responses.
module cascaded_8259_interrupt_controller_pair_tb;

    localparam logic [7:0]  ICW1_START    = 8'h10;
    localparam logic [7:0]  ICW1_IC4      = 8'h01;
    localparam logic [7:0]  ICW1_SNGL     = 8'h02;
    localparam logic [7:0]  OCW3_SEL      = 8'h08;
    localparam logic [7:0]  OCW3_POLL     = 8'h04;
    localparam logic [7:0]  OCW3_RR       = 8'h02;
    localparam logic [7:0]  OCW3_RIS      = 8'h01;
    localparam logic [7:0]  OCW2_EOI      = 8'h20;
    localparam logic [7:0]  OCW2_SL       = 8'h40;
    localparam logic [7:0]  OCW2_LEVEL    = 8'h07;
    localparam logic [7:0]  POLL_HIT      = 8'h80;
    localparam logic [11:0] PORT_KBD_DATA = 12'h060;
    localparam logic [11:0] PORT_KBD_CMD  = 12'h064;
    localparam int          PHASE_ITEMS   = 400;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
        logic       access_error;
    } t_pic_response;

    class pic_pair_scoreboard;
        logic [7:0]           mask_r[2];
        logic [7:0]           irr[2];
        logic [7:0]           isr[2];
        logic [7:0]           icw[8];
        pic_pkg::t_init_phase phase[2];
        bit                   need_icw4[2];
        bit                   single_mode[2];
        bit                   show_isr[2];
        bit                   poll_armed[2];
        logic [7:0]           elc[2];
        t_pic_response        expected_responses[$];
        int                   mismatches;

        function new();
            for (int c = 0; c < 2; c++) begin
                mask_r[c]      = '0;
                irr[c]         = '0;
                isr[c]         = '0;
                phase[c]       = pic_pkg::PH_OPER;
                need_icw4[c]   = 1'b0;
                single_mode[c] = 1'b0;
                show_isr[c]    = 1'b0;
                poll_armed[c]  = 1'b0;
                elc[c]         = '0;
            end
            foreach (icw[i]) begin
                icw[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_responses.size();
        endfunction

        function logic [2:0] first_set(logic [7:0] v);
            for (int i = 0; i < 7; i++) begin
                if (v[i]) begin
                    return 3'(i);
                end
            end
            return 3'd7;
        endfunction

        function logic [7:0] unmasked(int c);
            return irr[c] & ~mask_r[c];
        endfunction

        function void command_write(int c, logic [7:0] v);
            if ((v & ICW1_START) != 0) begin
                icw[c * 4]     = v;
                need_icw4[c]   = (v & ICW1_IC4) != 0;
                single_mode[c] = (v & ICW1_SNGL) != 0;
                mask_r[c]      = '0;
                isr[c]         = '0;
                show_isr[c]    = 1'b0;
                poll_armed[c]  = 1'b0;
                phase[c]       = pic_pkg::PH_ICW2;
            end else if ((v & OCW3_SEL) != 0) begin
                if ((v & OCW3_POLL) != 0) begin
                    poll_armed[c] = 1'b1;
                end else if ((v & OCW3_RR) != 0) begin
                    show_isr[c] = (v & OCW3_RIS) != 0;
                end
            end else if ((v & OCW2_EOI) != 0) begin
                if ((v & OCW2_SL) != 0) begin
                    isr[c][3'(v & OCW2_LEVEL)] = 1'b0;
                end else if (isr[c] != 0) begin
                    isr[c][first_set(isr[c])] = 1'b0;
                end
            end
        endfunction

        function void data_write(int c, logic [7:0] v);
            case (phase[c])
                pic_pkg::PH_ICW2: begin
                    icw[c * 4 + 1] = v;
                    if (single_mode[c]) begin
                        phase[c] = need_icw4[c] ? pic_pkg::PH_ICW4 : pic_pkg::PH_OPER;
                    end else begin
                        phase[c] = pic_pkg::PH_ICW3;
                    end
                end
                pic_pkg::PH_ICW3: begin
                    icw[c * 4 + 2] = v;
                    phase[c] = need_icw4[c] ? pic_pkg::PH_ICW4 : pic_pkg::PH_OPER;
                end
                pic_pkg::PH_ICW4: begin
                    icw[c * 4 + 3] = v;
                    phase[c] = pic_pkg::PH_OPER;
                end
                default: begin
                    mask_r[c] = v;
                end
            endcase
        endfunction

        function logic [7:0] command_read(int c);
            logic [7:0] p;
            logic [2:0] b;
            if (!poll_armed[c]) begin
                return show_isr[c] ? isr[c] : irr[c];
            end
            poll_armed[c] = 1'b0;
            p = unmasked(c);
            if (p == 0) begin
                return '0;
            end
            b = first_set(p);
            isr[c][b] = 1'b1;
            if (!(c == 0 && b == pic_pkg::CASCADE_BIT)) begin
                irr[c][b] = 1'b0;
            end
            return POLL_HIT | {5'd0, b};
        endfunction

        function void note_access(pic_pkg::t_op op, logic [11:0] off, logic [7:0] wd,
                                  logic [3:0] line);
            t_pic_response r;
            r = '0;
            case (op)
                pic_pkg::OP_READ: begin
                    case (off)
                        pic_pkg::PORT_MASTER_CMD:  r.read_data = command_read(0);
                        pic_pkg::PORT_MASTER_DATA: r.read_data = mask_r[0];
                        pic_pkg::PORT_SLAVE_CMD:   r.read_data = command_read(1);
                        pic_pkg::PORT_SLAVE_DATA:  r.read_data = mask_r[1];
                        pic_pkg::PORT_ELC0:        r.read_data = elc[0];
                        pic_pkg::PORT_ELC1:        r.read_data = elc[1];
                        default:                   r.access_error = 1'b1;
                    endcase
                end
                pic_pkg::OP_WRITE: begin
                    case (off)
                        pic_pkg::PORT_MASTER_CMD:  command_write(0, wd);
                        pic_pkg::PORT_MASTER_DATA: data_write(0, wd);
                        pic_pkg::PORT_SLAVE_CMD:   command_write(1, wd);
                        pic_pkg::PORT_SLAVE_DATA:  data_write(1, wd);
                        pic_pkg::PORT_ELC0:        elc[0] = wd;
                        pic_pkg::PORT_ELC1:        elc[1] = wd;
                        default:                   r.access_error = 1'b1;
                    endcase
                end
                pic_pkg::OP_RAISE: begin
                    irr[line[3]][line[2:0]] = 1'b1;
                end
                default: begin
                end
            endcase
            irr[0][pic_pkg::CASCADE_BIT] = unmasked(1) != 0;
            r.irq_level = unmasked(0) != 0;
            expected_responses.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(logic [7:0] rd, logic irq, logic err);
            t_pic_response e;
            if (expected_responses.size() == 0) begin
                report($sformatf("beat with nothing outstanding: data %02h irq %0b err %0b",
                                 rd, irq, err));
                return;
            end
            e = expected_responses.pop_front();
            if (rd !== e.read_data) begin
                report($sformatf("read_data %02h, predicted %02h", rd, e.read_data));
            end
            if (irq !== e.irq_level) begin
                report($sformatf("irq_level %0b, predicted %0b", irq, e.irq_level));
            end
            if (err !== e.access_error) begin
                report($sformatf("access_error %0b, predicted %0b", err, e.access_error));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [11:0] i_port_offset;
    logic [7:0]  i_write_data;
    logic [3:0]  i_request_line;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_read_data;
    logic        o_irq_level;
    logic        o_access_error;

    pic_pair_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;

    cascaded_8259_interrupt_controller_pair dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_port_offset  (i_port_offset),
        .i_write_data   (i_write_data),
        .i_request_line (i_request_line),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_irq_level    (o_irq_level),
        .o_access_error (o_access_error)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_response(o_read_data, o_irq_level, o_access_error);
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_beat(pic_pkg::t_op op, logic [11:0] off, logic [7:0] wd,
                             logic [3:0] line);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_port_offset  <= off;
        i_write_data   <= wd;
        i_request_line <= line;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.note_access(op, off, wd, line);
        if (op != pic_pkg::OP_NONE) begin
            beats_sent++;
        end
    endtask

    task automatic write_port(logic [11:0] off, logic [7:0] v);
        send_beat(pic_pkg::OP_WRITE, off, v, 4'($urandom));
    endtask

    task automatic read_port(logic [11:0] off);
        send_beat(pic_pkg::OP_READ, off, 8'($urandom), 4'($urandom));
    endtask

    task automatic raise_line(logic [3:0] line);
        send_beat(pic_pkg::OP_RAISE, 12'($urandom), 8'($urandom), line);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [11:0] any_port();
        case ($urandom_range(5))
            0:       return pic_pkg::PORT_MASTER_CMD;
            1:       return pic_pkg::PORT_MASTER_DATA;
            2:       return pic_pkg::PORT_SLAVE_CMD;
            3:       return pic_pkg::PORT_SLAVE_DATA;
            4:       return pic_pkg::PORT_ELC0;
            default: return pic_pkg::PORT_ELC1;
        endcase
    endfunction

    function automatic logic [7:0] sparse_mask();
        return $urandom_range(1) ? 8'($urandom) : 8'($urandom & $urandom & $urandom);
    endfunction

    task automatic init_sequence(logic [11:0] cmd_port, logic [11:0] data_port);
        logic [7:0] v;
        v = ICW1_START | 8'($urandom);
        write_port(cmd_port, v);
        if ($urandom_range(9) == 0) begin
            return;
        end
        write_port(data_port, 8'($urandom));
        if ((v & ICW1_SNGL) == 0) begin
            write_port(data_port, 8'($urandom));
        end
        if ((v & ICW1_IC4) != 0) begin
            write_port(data_port, 8'($urandom));
        end
        write_port(data_port, sparse_mask());
    endtask

    task automatic random_sequence();
        int          kind;
        bit          to_slave;
        logic [11:0] cmd_port;
        logic [11:0] data_port;
        logic [11:0] off;
        kind      = $urandom_range(99);
        to_slave  = $urandom_range(1);
        cmd_port  = to_slave ? pic_pkg::PORT_SLAVE_CMD : pic_pkg::PORT_MASTER_CMD;
        data_port = to_slave ? pic_pkg::PORT_SLAVE_DATA : pic_pkg::PORT_MASTER_DATA;
        if (kind < 24) begin
            raise_line(4'($urandom_range(15)));
        end else if (kind < 34) begin
            write_port(data_port, sparse_mask());
        end else if (kind < 46) begin
            write_port(cmd_port, OCW3_SEL | OCW3_POLL | (8'($urandom) & (OCW3_RR | OCW3_RIS)));
            read_port(cmd_port);
        end else if (kind < 56) begin
            if ($urandom_range(1)) begin
                write_port(cmd_port, OCW2_EOI);
            end else begin
                write_port(cmd_port, OCW2_EOI | OCW2_SL | (8'($urandom) & OCW2_LEVEL));
            end
        end else if (kind < 64) begin
            init_sequence(cmd_port, data_port);
        end else if (kind < 76) begin
            read_port(any_port());
        end else if (kind < 82) begin
            write_port(cmd_port, OCW3_SEL | (8'($urandom) & (OCW3_RR | OCW3_RIS)));
            read_port(cmd_port);
        end else if (kind < 86) begin
            write_port($urandom_range(1) ? pic_pkg::PORT_ELC0 : pic_pkg::PORT_ELC1,
                       8'($urandom));
        end else if (kind < 93) begin
            send_beat(pic_pkg::t_op'($urandom_range(3)), 12'($urandom), 8'($urandom),
                      4'($urandom));
        end else begin
            case ($urandom_range(2))
                0:       off = PORT_KBD_DATA;
                1:       off = PORT_KBD_CMD;
                default: off = any_port() ^ (12'd1 << $urandom_range(11));
            endcase
            if ($urandom_range(1)) begin
                read_port(off);
            end else begin
                write_port(off, 8'($urandom));
            end
        end
    endtask

    task automatic random_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        beats_sent     = 0;
        while (beats_sent < PHASE_ITEMS) begin
            random_sequence();
        end
        drain();
    endtask

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_operation    <= pic_pkg::OP_NONE;
        i_port_offset  <= '0;
        i_write_data   <= '0;
        i_request_line <= '0;
        i_stall        <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 29;
        recv_stall_pct = 86;
        read_port(pic_pkg::PORT_MASTER_CMD);
        write_port(pic_pkg::PORT_MASTER_CMD, ICW1_START);
        write_port(pic_pkg::PORT_MASTER_DATA, 8'h08);
        write_port(pic_pkg::PORT_MASTER_DATA, 8'h04);
        write_port(pic_pkg::PORT_SLAVE_CMD, ICW1_START | ICW1_SNGL | ICW1_IC4);
        write_port(pic_pkg::PORT_SLAVE_DATA, 8'h70);
        write_port(pic_pkg::PORT_SLAVE_DATA, 8'h01);
        write_port(pic_pkg::PORT_ELC0, 8'hFF);
        write_port(pic_pkg::PORT_ELC1, 8'h00);
        read_port(pic_pkg::PORT_ELC0);
        raise_line(4'd15);
        raise_line(4'd0);
        raise_line(4'd2);
        write_port(pic_pkg::PORT_MASTER_CMD, OCW3_SEL | OCW3_RR | OCW3_RIS);
        read_port(pic_pkg::PORT_MASTER_CMD);
        write_port(pic_pkg::PORT_MASTER_CMD, OCW3_SEL | OCW3_POLL | OCW3_RR);
        read_port(pic_pkg::PORT_MASTER_CMD);
        write_port(pic_pkg::PORT_SLAVE_CMD, OCW3_SEL | OCW3_POLL);
        read_port(pic_pkg::PORT_SLAVE_CMD);
        write_port(pic_pkg::PORT_MASTER_CMD, OCW2_EOI);
        write_port(pic_pkg::PORT_SLAVE_CMD, OCW2_EOI | OCW2_SL | OCW2_LEVEL);
        read_port(PORT_KBD_DATA);
        write_port(12'hFFF, 8'hFF);
        send_beat(pic_pkg::OP_NONE, pic_pkg::PORT_MASTER_CMD, 8'hFF, 4'hF);
        write_port(pic_pkg::PORT_MASTER_DATA, 8'hFF);
        read_port(pic_pkg::PORT_MASTER_DATA);
        drain();

        random_phase(29, 86);
        random_phase(86, 29);
        random_phase(0, 0);

        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/pic_pkg.sv
hw/rtl/pic_core.sv
hw/rtl/cascaded_8259_interrupt_controller_pair.sv
hw/rtl/pic_chk.sv
tb/sv/cascaded_8259_interrupt_controller_pair_tb.sv
